@@ design/sssf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sssf_pkg: shared constants for the seven-segment speed formatter
// Field widths, digit positions, segment codes and the digit-to-segment map.
// ----------------------------------------------------------------------------
package sssf_pkg;

    localparam int SPEED_W = 14;
    localparam int POS_W   = 2;
    localparam int SEG_W   = 8;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 14'd9999;

    // floor(x / 10) == (x * 6554) >> 16 for every x <= 9999
    localparam int                 DIV10_MUL_W = 13;
    localparam logic [12:0]        DIV10_MUL   = 13'd6554;
    localparam int                 DIV10_SHIFT = 16;

    localparam logic [POS_W-1:0] POS_HUNDREDS = 2'd0;
    localparam logic [POS_W-1:0] POS_TENS     = 2'd1;
    localparam logic [POS_W-1:0] POS_UNITS    = 2'd2;
    localparam logic [POS_W-1:0] POS_TENTHS   = 2'd3;

    localparam logic [SEG_W-1:0] SEG_BLANK   = 8'hFF;
    localparam logic [SEG_W-1:0] SEG_DP_MASK = 8'h7F;

    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

@@ design/seven_segment_speed_formatter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_speed_formatter_top: speed to seven-segment display writes
// Splits a speed in tenths into digits and emits active-low segment writes,
// tenths first, units with the decimal point, then tens and hundreds with
// leading-zero blanking.
//
//   channel | handshake                 | payload
//   --------+---------------------------+---------------------------------------
//   in      | i_in_valid / o_in_stall   | i_speed_tenths[13:0]
//   out     | o_out_valid / i_out_stall | o_digit_position[1:0],
//           |                           | o_segment_byte[7:0], o_last_write
//
// One request yields 6 to 8 writes, one per cycle while the output is not
// stalled. A request passes from the input register into the sequencer,
// and each write leaves through the output register. A new request is
// taken into the input register while the previous one is still being
// written. Output stall freezes the sequencer and the output register.
// Reset (synchronous, active low) empties both registers and the sequencer.
// ----------------------------------------------------------------------------
module seven_segment_speed_formatter_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [sssf_pkg::SPEED_W-1:0]  i_speed_tenths,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [sssf_pkg::POS_W-1:0]    o_digit_position,
    output logic [sssf_pkg::SEG_W-1:0]    o_segment_byte,
    output logic                          o_last_write
);

    typedef enum logic [2:0] {
        S_TENTHS,
        S_TENTHS_CLR,
        S_UNITS,
        S_UNITS_CLR,
        S_TENS,
        S_TENS_CLR,
        S_HUND,
        S_HUND_CLR
    } t_step;

    localparam int PROD_W = sssf_pkg::SPEED_W + sssf_pkg::DIV10_MUL_W;

    // input register
    logic                          r_in_valid;
    logic [sssf_pkg::SPEED_W-1:0]  r_in;

    // sequencer
    logic                          r_busy;
    t_step                         r_state;
    logic [sssf_pkg::SPEED_W-1:0]  r_rem;

    // output register
    logic                          r_out_valid;
    logic [sssf_pkg::POS_W-1:0]    r_pos;
    logic [sssf_pkg::SEG_W-1:0]    r_seg;
    logic                          r_last;

    logic [PROD_W-1:0]             w_prod;
    logic [sssf_pkg::SPEED_W-1:0]  w_quot;
    logic [sssf_pkg::SPEED_W-1:0]  w_ten;
    logic [3:0]                    w_digit;
    logic [sssf_pkg::SPEED_W-1:0]  w_sat;
    logic                          w_out_free;
    logic                          w_adv;
    logic                          w_load;
    logic                          w_in_acc;

    t_step                         n_state;
    logic [sssf_pkg::POS_W-1:0]    n_pos;
    logic [sssf_pkg::SEG_W-1:0]    n_seg;
    logic                          n_last;
    logic                          n_div;

    assign w_sat = (i_speed_tenths > sssf_pkg::SPEED_MAX) ? sssf_pkg::SPEED_MAX
                                                          : i_speed_tenths;

    // remaining value split into last digit and quotient
    assign w_prod  = PROD_W'(r_rem) * PROD_W'(sssf_pkg::DIV10_MUL);
    assign w_quot  = sssf_pkg::SPEED_W'(w_prod >> sssf_pkg::DIV10_SHIFT);
    assign w_ten   = sssf_pkg::SPEED_W'(w_quot << 3) + sssf_pkg::SPEED_W'(w_quot << 1);
    assign w_digit = 4'(r_rem - w_ten);

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = r_busy && w_out_free;
    assign w_load     = r_in_valid && (!r_busy || (w_adv && n_last));
    assign o_in_stall = r_in_valid && !w_load;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        n_pos   = sssf_pkg::POS_TENTHS;
        n_seg   = sssf_pkg::SEG_BLANK;
        n_last  = 1'b0;
        n_div   = 1'b0;
        case (r_state)
            S_TENTHS: begin
                n_seg   = sssf_pkg::seg_of(w_digit);
                n_div   = 1'b1;
                n_state = S_TENTHS_CLR;
            end
            S_TENTHS_CLR: begin
                n_state = S_UNITS;
            end
            S_UNITS: begin
                n_pos   = sssf_pkg::POS_UNITS;
                n_seg   = sssf_pkg::seg_of(w_digit) & sssf_pkg::SEG_DP_MASK;
                n_div   = 1'b1;
                n_state = S_UNITS_CLR;
            end
            S_UNITS_CLR: begin
                n_pos   = sssf_pkg::POS_UNITS;
                n_state = S_TENS;
            end
            S_TENS: begin
                n_pos = sssf_pkg::POS_TENS;
                if (r_rem != '0) begin
                    n_seg   = sssf_pkg::seg_of(w_digit);
                    n_div   = 1'b1;
                    n_state = S_TENS_CLR;
                end else begin
                    n_state = S_HUND;
                end
            end
            S_TENS_CLR: begin
                n_pos   = sssf_pkg::POS_TENS;
                n_state = S_HUND;
            end
            S_HUND: begin
                n_pos = sssf_pkg::POS_HUNDREDS;
                if (r_rem != '0) begin
                    n_seg   = sssf_pkg::seg_of(w_digit);
                    n_div   = 1'b1;
                    n_state = S_HUND_CLR;
                end else begin
                    n_last  = 1'b1;
                    n_state = S_TENTHS;
                end
            end
            S_HUND_CLR: begin
                n_pos   = sssf_pkg::POS_HUNDREDS;
                n_last  = 1'b1;
                n_state = S_TENTHS;
            end
            default: begin
                n_state = S_TENTHS;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_busy      <= 1'b0;
            r_state     <= S_TENTHS;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
                r_in       <= w_sat;
            end else if (w_load) begin
                r_in_valid <= 1'b0;
            end

            if (w_out_free) begin
                r_out_valid <= w_adv;
            end
            if (w_adv) begin
                r_pos  <= n_pos;
                r_seg  <= n_seg;
                r_last <= n_last;
            end

            if (w_load) begin
                r_busy  <= 1'b1;
                r_state <= S_TENTHS;
                r_rem   <= r_in;
            end else if (w_adv) begin
                r_state <= n_state;
                if (n_last) begin
                    r_busy <= 1'b0;
                end
                if (n_div) begin
                    r_rem <= w_quot;
                end
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_digit_position = r_pos;
    assign o_segment_byte   = r_seg;
    assign o_last_write     = r_last;

    // final write of a request always lands on the hundreds position
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_write) |-> (o_digit_position == sssf_pkg::POS_HUNDREDS))
        else $error("last write not at hundreds position");

    // writes of one request follow each other without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last_write) |=> o_out_valid)
        else $error("gap inside a request's write sequence");

    // a waiting request starts as soon as the sequencer is idle
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_busy) |=> (r_busy && r_state == S_TENTHS))
        else $error("pending request not loaded");

    // the first write of a request is the tenths position
    a_first_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_state == S_TENTHS) |=> (o_digit_position == sssf_pkg::POS_TENTHS))
        else $error("first write not at tenths position");

endmodule

@@ verif/tb_seven_segment_speed_formatter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seven_segment_speed_formatter_top: self-checking bench for the formatter
// Sends speed requests: first directed edge values, then random ones, with
// random gaps on the input and random stalls on the output. Expected display
// writes are computed per accepted request and compared in order.
// ----------------------------------------------------------------------------
module tb_seven_segment_speed_formatter_top;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;

    localparam logic [sssf_pkg::SEG_W-1:0] DIGIT_SEG [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    localparam logic [sssf_pkg::SPEED_W-1:0] EDGE_SPEEDS [23] = '{
        14'd0, 14'd1, 14'd9, 14'd10, 14'd11, 14'd19, 14'd99, 14'd100, 14'd101,
        14'd109, 14'd999, 14'd1000, 14'd1001, 14'd1010, 14'd1234, 14'd5678,
        14'd9990, 14'd9999, 14'd10000, 14'd16383, 14'd8191, 14'd12345, 14'd4096
    };

    typedef struct packed {
        logic [sssf_pkg::POS_W-1:0] pos;
        logic [sssf_pkg::SEG_W-1:0] seg;
        logic                       last_write;
    } t_disp_write;

    class t_segment_write_board;
        t_disp_write pending_writes[$];
        int          mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void add_write(logic [sssf_pkg::POS_W-1:0] pos,
                                logic [sssf_pkg::SEG_W-1:0] seg);
            t_disp_write w;
            w.pos        = pos;
            w.seg        = seg;
            w.last_write = 1'b0;
            pending_writes.push_back(w);
        endfunction

        function void note_speed(logic [sssf_pkg::SPEED_W-1:0] raw);
            int unsigned v;
            int unsigned whole;
            t_disp_write w;
            v     = 32'((raw > sssf_pkg::SPEED_MAX) ? sssf_pkg::SPEED_MAX : raw);
            whole = v / 10;
            add_write(sssf_pkg::POS_TENTHS, DIGIT_SEG[4'(v % 10)]);
            add_write(sssf_pkg::POS_TENTHS, sssf_pkg::SEG_BLANK);
            add_write(sssf_pkg::POS_UNITS,
                      DIGIT_SEG[4'(whole % 10)] & sssf_pkg::SEG_DP_MASK);
            add_write(sssf_pkg::POS_UNITS, sssf_pkg::SEG_BLANK);
            whole = whole / 10;
            // leading positions blank once the integer part runs out
            if (whole > 0) begin
                add_write(sssf_pkg::POS_TENS, DIGIT_SEG[4'(whole % 10)]);
                add_write(sssf_pkg::POS_TENS, sssf_pkg::SEG_BLANK);
            end else begin
                add_write(sssf_pkg::POS_TENS, sssf_pkg::SEG_BLANK);
            end
            whole = whole / 10;
            if (whole > 0) begin
                add_write(sssf_pkg::POS_HUNDREDS, DIGIT_SEG[4'(whole % 10)]);
                add_write(sssf_pkg::POS_HUNDREDS, sssf_pkg::SEG_BLANK);
            end else begin
                add_write(sssf_pkg::POS_HUNDREDS, sssf_pkg::SEG_BLANK);
            end
            w = pending_writes.pop_back();
            w.last_write = 1'b1;
            pending_writes.push_back(w);
        endfunction

        function void check_write(logic [sssf_pkg::POS_W-1:0] pos,
                                  logic [sssf_pkg::SEG_W-1:0] seg,
                                  logic last_write);
            t_disp_write w;
            if (pending_writes.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected write: pos=%0d seg=%02h last=%0d",
                             pos, seg, last_write);
                mismatches++;
            end else begin
                w = pending_writes.pop_front();
                if (w.pos !== pos || w.seg !== seg || w.last_write !== last_write) begin
                    if (mismatches < 10)
                        $display("write mismatch: exp pos=%0d seg=%02h last=%0d,",
                                 w.pos, w.seg, w.last_write,
                                 " got pos=%0d seg=%02h last=%0d",
                                 pos, seg, last_write);
                    mismatches++;
                end
            end
        endfunction

        function int pending_count();
            return pending_writes.size();
        endfunction
    endclass

    logic                            i_clk            = 1'b0;
    logic                            i_rst_n          = 1'b0;
    logic                            i_in_valid       = 1'b0;
    logic [sssf_pkg::SPEED_W-1:0]    i_speed_tenths   = '0;
    logic                            i_out_stall      = 1'b0;
    logic                            o_in_stall;
    logic                            o_out_valid;
    logic [sssf_pkg::POS_W-1:0]      o_digit_position;
    logic [sssf_pkg::SEG_W-1:0]      o_segment_byte;
    logic                            o_last_write;

    t_segment_write_board sb = new();
    bit                   calm     = 1'b0;
    bit                   hold_req = 1'b0;
    int                   cycles   = 0;

    seven_segment_speed_formatter_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_speed_tenths   (i_speed_tenths),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_digit_position (o_digit_position),
        .o_segment_byte   (o_segment_byte),
        .o_last_write     (o_last_write)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_write(o_digit_position, o_segment_byte, o_last_write);
    end

    // output stall pattern; a long hold-off when requested
    initial begin
        int r;
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (calm) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    i_out_stall <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end else if (r < 85) begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else if (r < 97) begin
                    i_out_stall <= 1'b0;
                    repeat ($urandom_range(5, 20)) @(posedge i_clk);
                end else begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(15, 40)) @(posedge i_clk);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [sssf_pkg::SPEED_W-1:0] pick_speed();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return sssf_pkg::SPEED_W'($urandom_range(0, 9999));
        else if (r < 58)
            return sssf_pkg::SPEED_W'($urandom_range(0, 99));
        else if (r < 68)
            return sssf_pkg::SPEED_W'($urandom_range(0, 9));
        else if (r < 78)
            return sssf_pkg::SPEED_W'($urandom_range(100, 999));
        else if (r < 88)
            return sssf_pkg::SPEED_W'($urandom_range(9900, 9999));
        else if (r < 95)
            return sssf_pkg::SPEED_W'($urandom_range(10000, 16383));
        else
            return sssf_pkg::SPEED_W'($urandom_range(0, 16383));
    endfunction

    // offer one request, keep valid high afterwards unless a gap follows
    task automatic send_speed(input logic [sssf_pkg::SPEED_W-1:0] speed);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_speed_tenths <= speed;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_speed(speed);
    endtask

    task automatic drain_writes();
        i_in_valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
    endtask

    initial begin
        int errs;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (EDGE_SPEEDS[k])
            send_speed(EDGE_SPEEDS[k]);
        drain_writes();

        repeat (110) send_speed(pick_speed());

        // receiver holds off while requests keep coming, then a stall-free run
        hold_req = 1'b1;
        calm     = 1'b1;
        repeat (80) send_speed(pick_speed());
        calm     = 1'b0;
        drain_writes();

        repeat (120) send_speed(pick_speed());
        drain_writes();
        repeat (20) @(posedge i_clk);

        errs = sb.mismatches + sb.pending_count();
        if (sb.pending_count() != 0)
            $display("%0d expected writes never arrived", sb.pending_count());
        if (errs == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ seven_segment_speed_formatter_top.f @@
design/sssf_pkg.sv
design/seven_segment_speed_formatter_top.sv
verif/tb_seven_segment_speed_formatter_top.sv
